// ===== hw/rtl/knn_pkg.sv =====
// package: shared types and constants of the nearest neighbor search
`timescale 1ns / 1ps
package knn_pkg;
	localparam int MAX_POINTS    = 1024;
	localparam int MAX_NEIGHBORS = 16;
	localparam int COORD_BITS    = 16;
	localparam int IDX_BITS      = $clog2(MAX_POINTS);
	localparam int CNT_BITS      = $clog2(MAX_POINTS + 1);
	localparam int SLOT_BITS     = $clog2(MAX_NEIGHBORS);
	localparam int FILL_BITS     = $clog2(MAX_NEIGHBORS + 1);
	localparam int DIST_BITS     = 2 * COORD_BITS + 1;
	localparam int KCFG_BITS     = 5;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0]                    mode;
		logic signed [COORD_BITS-1:0] coord_x;
		logic signed [COORD_BITS-1:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic [IDX_BITS-1:0]           neighbor_index;
		logic signed [COORD_BITS-1:0] neighbor_x;
		logic signed [COORD_BITS-1:0] neighbor_y;
		logic [DIST_BITS-1:0]          squared_distance;
		logic                          last_neighbor;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic                 take_item;  // capture input item
		logic                 load_wr;    // write captured point to store
		logic                 clear;      // empty the store
		logic                 list_clr;   // empty the best list
		logic                 rd_emit;    // read store at best slot
		logic                 scan_inc;   // advance scan index
		logic                 insert;     // consider distance of the s3 point
		logic                 emit_inc;   // advance emit slot
	} knn_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] mode;
		logic       store_full;
		logic       store_empty;
		logic       scan_last;   // scan index is on the last stored point
		logic       emit_last;   // emit slot is on the last kept entry
	} knn_sts_t;
endpackage

// ===== hw/rtl/knn_datapath.sv =====
// datapath: point store, distance pipeline, sorted best list and result register
`timescale 1ns / 1ps
module knn_datapath import knn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_item,
	input  logic [KCFG_BITS-1:0] neighbor_count,
	input  knn_cmd_t             cmd,
	output knn_sts_t             sts,
	output out_item_t            res_item
);
	logic signed [COORD_BITS-1:0] mem_x [MAX_POINTS];
	logic signed [COORD_BITS-1:0] mem_y [MAX_POINTS];

	in_item_t            item_q;
	logic [CNT_BITS-1:0] count_q;
	logic [IDX_BITS-1:0] scan_q;
	logic [SLOT_BITS-1:0] emit_q;
	logic [FILL_BITS-1:0] fill_q;
	logic [FILL_BITS-1:0] k_eff;

	logic signed [COORD_BITS-1:0] rx_s1, ry_s1;
	logic [IDX_BITS-1:0]          idx_s1;
	logic [COORD_BITS:0]          dx_s2, dy_s2;
	logic [IDX_BITS-1:0]          idx_s2;
	logic [2*COORD_BITS-1:0]      sx_s3, sy_s3;
	logic [IDX_BITS-1:0]          idx_s3;
	logic [DIST_BITS-1:0]         dist_s3;

	logic [DIST_BITS-1:0] best_d_q [MAX_NEIGHBORS];
	logic [IDX_BITS-1:0]  best_i_q [MAX_NEIGHBORS];
	logic [IDX_BITS-1:0]  rd_addr;

	// effective neighbor count, clamped to 1..MAX_NEIGHBORS
	always_comb begin
		if (neighbor_count == '0)
			k_eff = FILL_BITS'(1);
		else if (32'(neighbor_count) > MAX_NEIGHBORS)
			k_eff = FILL_BITS'(MAX_NEIGHBORS);
		else
			k_eff = FILL_BITS'(neighbor_count);
	end

	// captured item
	always_ff @(posedge clk) begin
		if (cmd.take_item)
			item_q <= in_item;
	end

	// stored point count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clear) begin
			count_q <= '0;
		end else if (cmd.load_wr) begin
			count_q <= count_q + 1'b1;
		end
	end

	// point store
	assign rd_addr = cmd.rd_emit ? best_i_q[emit_q] : scan_q;
	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem_x[count_q[IDX_BITS-1:0]] <= item_q.coord_x;
			mem_y[count_q[IDX_BITS-1:0]] <= item_q.coord_y;
		end
		rx_s1  <= mem_x[rd_addr];
		ry_s1  <= mem_y[rd_addr];
		idx_s1 <= rd_addr;
	end

	// scan and emit counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			emit_q <= '0;
		end else begin
			if (cmd.take_item)
				scan_q <= '0;
			else if (cmd.scan_inc)
				scan_q <= scan_q + 1'b1;
			if (cmd.list_clr)
				emit_q <= '0;
			else if (cmd.emit_inc)
				emit_q <= emit_q + 1'b1;
		end
	end

	// distance pipeline: difference, square, sum
	always_ff @(posedge clk) begin
		logic signed [COORD_BITS:0] ddx, ddy;
		ddx = {item_q.coord_x[COORD_BITS-1], item_q.coord_x} - {rx_s1[COORD_BITS-1], rx_s1};
		ddy = {item_q.coord_y[COORD_BITS-1], item_q.coord_y} - {ry_s1[COORD_BITS-1], ry_s1};
		dx_s2   <= ddx[COORD_BITS] ? -ddx : ddx;
		dy_s2   <= ddy[COORD_BITS] ? -ddy : ddy;
		idx_s2  <= idx_s1;
		sx_s3   <= (2*COORD_BITS)'(dx_s2 * dx_s2);
		sy_s3   <= (2*COORD_BITS)'(dy_s2 * dy_s2);
		idx_s3  <= idx_s2;
	end
	assign dist_s3 = {1'b0, sx_s3} + {1'b0, sy_s3};

	// sorted insertion into the best list, one candidate per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.list_clr) begin
			fill_q <= '0;
		end else if (cmd.insert) begin
			if (fill_q < k_eff)
				fill_q <= fill_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		logic lt [MAX_NEIGHBORS];
		for (int j = 0; j < MAX_NEIGHBORS; j++)
			lt[j] = (j < 32'(fill_q)) && (dist_s3 < best_d_q[j]);
		if (cmd.insert) begin
			for (int j = 0; j < MAX_NEIGHBORS; j++) begin
				if (j < 32'(k_eff)) begin
					if (lt[j] && (j == 0 || !lt[j-1])) begin
						best_d_q[j] <= dist_s3;
						best_i_q[j] <= idx_s3;
					end else if (j > 0 && lt[j-1]) begin
						best_d_q[j] <= best_d_q[j-1];
						best_i_q[j] <= best_i_q[j-1];
					end else if (j == 32'(fill_q) && !(j > 0 && lt[j-1])) begin
						best_d_q[j] <= dist_s3;
						best_i_q[j] <= idx_s3;
					end
				end
			end
		end
	end

	// result register, loaded from s1 read of the emitted slot
	logic [SLOT_BITS-1:0] emit_s1;
	logic                 emit_v_s1;
	always_ff @(posedge clk) begin
		emit_s1   <= emit_q;
		emit_v_s1 <= cmd.rd_emit;
	end
	always_comb begin
		res_item.neighbor_index   = idx_s1;
		res_item.neighbor_x       = rx_s1;
		res_item.neighbor_y       = ry_s1;
		res_item.squared_distance = best_d_q[emit_s1];
		res_item.last_neighbor    = emit_v_s1 && (32'(emit_s1) + 1 == 32'(fill_q));
	end

	assign sts.mode        = item_q.mode;
	assign sts.store_full  = (32'(count_q) >= MAX_POINTS);
	assign sts.store_empty = (count_q == '0);
	assign sts.scan_last   = (32'(scan_q) + 1 == 32'(count_q));
	assign sts.emit_last   = (32'(emit_q) + 1 == 32'(fill_q));
endmodule

// ===== hw/rtl/knn_ctrl.sv =====
// controller: sequences load, clear, scan and result emission
`timescale 1ns / 1ps
module knn_ctrl import knn_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  knn_sts_t sts,
	output knn_cmd_t cmd,
	output logic     busy
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DEC   = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;
	logic [1:0] drain_q;
	logic       accept;
	logic       ins_s1, ins_s2, ins_s3;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign busy      = (state_q != ST_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		cmd.take_item = accept;
		case (state_q)
			ST_DEC: begin
				cmd.load_wr  = (sts.mode == MODE_LOAD) && !sts.store_full;
				cmd.clear    = (sts.mode == MODE_CLEAR);
				cmd.list_clr = (sts.mode == MODE_QUERY);
			end
			ST_SCAN:  cmd.scan_inc = 1'b1;
			ST_RD:    cmd.rd_emit  = 1'b1;
			// keep reading the emitted slot so a stalled result holds
			ST_OUT: begin
				cmd.rd_emit  = 1'b1;
				cmd.emit_inc = !out_stall;
			end
			default:  ;
		endcase
		cmd.insert = ins_s3;
	end

	// track scan reads through the three stage distance pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ins_s1 <= 1'b0;
			ins_s2 <= 1'b0;
			ins_s3 <= 1'b0;
		end else begin
			ins_s1 <= (state_q == ST_SCAN);
			ins_s2 <= ins_s1;
			ins_s3 <= ins_s2;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_DEC;
				ST_DEC: begin
					if (sts.mode == MODE_QUERY && !sts.store_empty)
						state_q <= ST_SCAN;
					else
						state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (sts.scan_last) begin
						state_q <= ST_DRAIN;
						drain_q <= 2'd3;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 1'b1;
					if (drain_q == 2'd1)
						state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_OUT;
				ST_OUT: begin
					if (!out_stall)
						state_q <= sts.emit_last ? ST_IDLE : ST_RD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/k_nearest_neighbor_search.sv =====
// top level: brute force two dimensional k nearest neighbor search
`timescale 1ns / 1ps
// Usage:
// in channel (in_valid, in_stall, in_data) carries one transaction per item:
// mode load appends a point, mode clear empties the store, mode query scans.
// out channel (out_valid, out_stall, out_data) returns the kept neighbors of
// a query nearest first, ties by lower load index, last_neighbor on the last.
// cfg channel (cfg_valid, cfg_ready, cfg_data) writes neighbor_count; write
// only while the block is idle. cfg_ready is always high.
// Load, clear and unused modes pass through the decode state and return to
// idle. A query scans the N stored points through the single store read
// port and a three stage distance pipe, drains the pipe, then emits each
// result through a read state and an output state.
// One item is in flight at a time; in_stall stays high until it is done.
// Reset empties the store, the best list and sets neighbor_count to 1.
// While out_stall is high the result holds and the block waits.
module k_nearest_neighbor_search import knn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [KCFG_BITS-1:0] cfg_data
);
	knn_cmd_t             cmd;
	knn_sts_t             sts;
	logic [KCFG_BITS-1:0] k_q;
	logic                 busy;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			k_q <= KCFG_BITS'(1);
		else if (cfg_valid && cfg_ready)
			k_q <= cfg_data;
	end

	knn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd),
		.busy(busy)
	);

	knn_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .neighbor_count(k_q),
		.cmd(cmd), .sts(sts), .res_item(out_data)
	);

`ifndef SYNTHESIS
	// no input transaction while busy
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall) else $error("accepted while busy");
	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");
	// results never appear while idle
	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy) else $error("result while idle");
`endif
endmodule
